/* design/deq_pkg.sv */
// Shared constants, types and helper functions for the double-ended queue.
package deq_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int PTR_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  localparam int CMD_W   = 3;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;
  localparam int ERR_W   = 2;

  localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd3;

  localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
  localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
  localparam logic [ERR_W-1:0] ERR_FULL  = 2'd2;

  typedef enum logic [1:0] {
    DQ_IDLE,
    DQ_READ,
    DQ_RESP
  } deq_state_t;

  typedef struct packed {
    logic                  we;
    logic [PTR_W-1:0]      waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic [PTR_W-1:0]      raddr_front;
    logic [PTR_W-1:0]      raddr_back;
  } mem_req_t;

  // (pos + off) mod DEPTH; off never exceeds DEPTH for live entries
  function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] pos,
                                                input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = {{(CNT_W + 1 - PTR_W){1'b0}}, pos} + {1'b0, off};
    if (sum >= (CNT_W + 1)'(DEPTH)) begin
      sum = sum - (CNT_W + 1)'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

  function automatic logic [DATA_WIDTH-1:0] store_word(input logic [VALUE_W-1:0] v);
    logic [63:0] ext;
    ext = {{(64 - VALUE_W){v[VALUE_W-1]}}, v};
    return ext[DATA_WIDTH-1:0];
  endfunction

  function automatic logic [VALUE_W-1:0] out_word(input logic [DATA_WIDTH-1:0] w);
    logic [63:0] ext;
    ext = {{(64 - DATA_WIDTH){w[DATA_WIDTH-1]}}, w};
    return ext[VALUE_W-1:0];
  endfunction

endpackage

/* design/deq_if.sv */
// Valid/ready channel interfaces for commands in and results out.
interface deq_in_if import deq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [VALUE_W-1:0] value;

  modport source (output valid, command, value, input ready);
  modport sink   (input valid, command, value, output ready);
endinterface

interface deq_out_if import deq_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] front_value;
  logic [VALUE_W-1:0] back_value;
  logic [COUNT_W-1:0] count;
  logic [ERR_W-1:0]   error;

  modport source (output valid, front_value, back_value, count, error, input ready);
  modport sink   (input valid, front_value, back_value, count, error, output ready);
endinterface

/* design/double_ended_queue_top.sv */
// Top level of the double-ended queue: sequencer plus two mirrored slot stores.
//
// Bounded deque of signed words (DEPTH entries) held in a ring store.
// in_chan carries one command beat: command (push back, push front,
// pop back, pop front, peek) and value. out_chan returns exactly one beat
// per command: front and back values after the operation (all ones when
// empty), the entry count and an error code (pop on empty, push on full;
// the offending command leaves the queue unchanged).
// Each command goes from acceptance to result in order: the pointers are
// updated and the store written, the end addresses are presented, and the
// registered read data is captured. A new command is taken only once the
// previous one has reached the output register; the slot store is
// duplicated so both ends are read in the same cycle.
// The result sits in an output register, so a new command is accepted while
// an earlier result still waits; if the receiver stalls, the next result
// holds in the sequencer and in_chan.ready stays low until it is taken.
// Synchronous active-low reset empties the queue and drops any pending beat.
module double_ended_queue_top import deq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  deq_in_if.sink    in_chan,
  deq_out_if.source out_chan
);

  mem_req_t              mem_req;
  logic [DATA_WIDTH-1:0] rdata_front;
  logic [DATA_WIDTH-1:0] rdata_back;

  deq_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .mem_req     (mem_req),
    .rdata_front (rdata_front),
    .rdata_back  (rdata_back)
  );

  // both copies take every write; each serves one end of the queue
  deq_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_ram_front (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr_front),
    .rdata (rdata_front)
  );

  deq_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_ram_back (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .raddr (mem_req.raddr_back),
    .rdata (rdata_back)
  );

endmodule

/* design/deq_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/deq_ctrl.sv */
// Command sequencer: ring pointers, store writes, end-value reads and result register.
module deq_ctrl import deq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  deq_in_if.sink                in_chan,
  deq_out_if.source             out_chan,
  output mem_req_t              mem_req,
  input  logic [DATA_WIDTH-1:0] rdata_front,
  input  logic [DATA_WIDTH-1:0] rdata_back
);

  deq_state_t         state_r, state_nxt;
  logic [PTR_W-1:0]   head_r, head_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [ERR_W-1:0]   err_r, err_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [VALUE_W-1:0] front_r, back_r;
  logic [COUNT_W-1:0] count_r;
  logic [ERR_W-1:0]   error_r;
  logic               accept;
  logic               load_out;
  logic               is_full;
  logic               is_empty;

  assign in_chan.ready = (state_r == DQ_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;
  assign is_full       = (cnt_r == CNT_W'(DEPTH));
  assign is_empty      = (cnt_r == '0);

  always_comb begin
    // end reads follow the pointers; data is ready in the cycle after they settle
    mem_req.raddr_front = head_r;
    mem_req.raddr_back  = ring_add(head_r, cnt_r - CNT_W'(1));
    mem_req.wdata       = store_word(in_chan.value);
    state_nxt     = state_r;
    head_nxt      = head_r;
    cnt_nxt       = cnt_r;
    err_nxt       = err_r;
    out_valid_nxt = out_valid_r;
    load_out      = 1'b0;
    mem_req.we    = 1'b0;
    mem_req.waddr = ring_add(head_r, cnt_r);

    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      DQ_IDLE: begin
        if (accept) begin
          err_nxt   = ERR_NONE;
          state_nxt = DQ_READ;
          unique case (in_chan.command)
            CMD_PUSH_BACK: begin
              if (is_full) begin
                err_nxt = ERR_FULL;
              end else begin
                mem_req.we = 1'b1;
                cnt_nxt    = cnt_r + CNT_W'(1);
              end
            end
            CMD_PUSH_FRONT: begin
              if (is_full) begin
                err_nxt = ERR_FULL;
              end else begin
                head_nxt      = ring_add(head_r, CNT_W'(DEPTH - 1));
                mem_req.waddr = head_nxt;
                mem_req.we    = 1'b1;
                cnt_nxt       = cnt_r + CNT_W'(1);
              end
            end
            CMD_POP_BACK: begin
              if (is_empty) begin
                err_nxt = ERR_EMPTY;
              end else begin
                cnt_nxt = cnt_r - CNT_W'(1);
              end
            end
            CMD_POP_FRONT: begin
              if (is_empty) begin
                err_nxt = ERR_EMPTY;
              end else begin
                head_nxt = ring_add(head_r, CNT_W'(1));
                cnt_nxt  = cnt_r - CNT_W'(1);
              end
            end
            default: begin
              // peek and unused codes leave the queue alone
            end
          endcase
        end
      end
      DQ_READ: begin
        state_nxt = DQ_RESP;
      end
      DQ_RESP: begin
        if (!out_valid_r || out_chan.ready) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = DQ_IDLE;
        end
      end
      default: begin
        state_nxt = DQ_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= DQ_IDLE;
      head_r      <= '0;
      cnt_r       <= '0;
      err_r       <= ERR_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      cnt_r       <= cnt_nxt;
      err_r       <= err_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      front_r <= is_empty ? '1 : out_word(rdata_front);
      back_r  <= is_empty ? '1 : out_word(rdata_back);
      count_r <= COUNT_W'(cnt_r);
      error_r <= err_r;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.front_value = front_r;
  assign out_chan.back_value  = back_r;
  assign out_chan.count       = count_r;
  assign out_chan.error       = error_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("entry count beyond depth");

  a_accept_to_read: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == DQ_READ)
    else $error("accepted beat did not start the read");

  a_write_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.we |-> accept && !is_full)
    else $error("store write outside an accepted push");

  a_result_from_resp: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == DQ_RESP))
    else $error("result raised outside the response step");

endmodule
